>>> rtl/core/utqb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utqb_pkg
// Shared types and constants for the UART transmit queue with bypass.
// ----------------------------------------------------------------------------
package utqb_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned COUNT_OUT_W = 7;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_TXDONE = 1'b1
  } op_e;

  // ring port request from control to storage
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic                   done;
    logic                   accepted;
    logic                   tx_load;
    logic [7:0]             tx_byte;
    logic                   sending;
    logic [COUNT_OUT_W-1:0] queued;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/utqb_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utqb_ring
// Byte ring storage with one write and one registered read port. A write to
// the address being read in the same cycle is forwarded to the head output.
// ----------------------------------------------------------------------------
module utqb_ring
  import utqb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ring_req_t req_i,
  output logic [7:0]     head_o
);

  logic [7:0] mem [QUEUE_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q    <= mem[req_i.raddr];
    fwd_data_q <= req_i.wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  assign head_o = fwd_q ? fwd_data_q : rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/utqb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utqb_ctrl
// Input register, queue state and single-pass update logic, result register.
// ----------------------------------------------------------------------------
module utqb_ctrl
  import utqb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       operation_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       message_start_i,
  input  wire logic [7:0] head_i,
  output ring_req_t       ring_req_o,
  output result_t         res_o
);

  // input register
  logic       in_vld_q;
  op_e        op_q;
  logic [7:0] byte_q;
  logic       start_q;

  // queue state
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             hfree_q, hfree_d;
  logic             sending_q, sending_d;

  // result register
  result_t res_q, res_d;
  logic    we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      op_q    <= op_e'(operation_i);
      byte_q  <= data_byte_i;
      start_q <= message_start_i;
    end
  end

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    cnt_d     = cnt_q;
    hfree_d   = hfree_q;
    sending_d = sending_q;
    we        = 1'b0;
    res_d     = '0;

    if (in_vld_q) begin
      res_d.done     = 1'b1;
      res_d.accepted = 1'b1;
      case (op_q)
        OP_WRITE: begin
          if (start_q) begin
            sending_d = 1'b1;
            hfree_d   = 1'b1;
          end
          if (cnt_q == CNT_FULL) begin
            res_d.accepted = 1'b0;
          end else if (hfree_d) begin
            // bypass the ring
            res_d.tx_load = 1'b1;
            res_d.tx_byte = byte_q;
            hfree_d       = 1'b0;
          end else begin
            we       = 1'b1;
            wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end
        end
        OP_TXDONE: begin
          hfree_d = 1'b1;
          if (cnt_q != '0) begin
            res_d.tx_load = 1'b1;
            res_d.tx_byte = head_i;
            rd_ptr_d      = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
            cnt_d         = cnt_q - 1'b1;
            hfree_d       = 1'b0;
          end else begin
            sending_d = 1'b0;
          end
        end
        default: begin
          res_d.accepted = 1'b0;
        end
      endcase
      res_d.sending = sending_d;
      res_d.queued  = COUNT_OUT_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      hfree_q   <= 1'b0;
      sending_q <= 1'b0;
      res_q     <= '0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      cnt_q     <= cnt_d;
      hfree_q   <= hfree_d;
      sending_q <= sending_d;
      res_q     <= res_d;
    end
  end

  // read ahead at the pointer the next word will see
  assign ring_req_o.we    = we;
  assign ring_req_o.waddr = wr_ptr_q;
  assign ring_req_o.wdata = byte_q;
  assign ring_req_o.raddr = rd_ptr_d;

  assign res_o = res_q;

endmodule
`default_nettype wire

>>> rtl/core/uart_tx_queue_with_bypass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx_queue_with_bypass
// Transmit byte queue in front of a UART holding register, with direct load
// when the holding register is free.
// ----------------------------------------------------------------------------
// Result path: a word taken at a start edge shows its result with done_o
//   after the input register and then the result register.
// Throughput: one word per cycle; busy stays low, the ring read is prefetched.
// Reset: pointers, fill count and flags clear; ring contents stay unknown.
// The receiver cannot stall: each result is held for one cycle only.
module uart_tx_queue_with_bypass
  import utqb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       operation_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       message_start_i,
  output logic            done_o,
  output logic            accepted_o,
  output logic            tx_load_o,
  output logic [7:0]      tx_byte_o,
  output logic            sending_flag_o,
  output logic [6:0]      queued_count_o
);

  ring_req_t  ring_req;
  logic [7:0] head;
  result_t    res;
  logic       take;

  assign busy = 1'b0;
  assign take = start && !busy;

  utqb_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (take),
    .operation_i     (operation_i),
    .data_byte_i     (data_byte_i),
    .message_start_i (message_start_i),
    .head_i          (head),
    .ring_req_o      (ring_req),
    .res_o           (res)
  );

  utqb_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .head_o (head)
  );

  assign done_o         = res.done;
  assign accepted_o     = res.accepted;
  assign tx_load_o      = res.tx_load;
  assign tx_byte_o      = res.tx_byte;
  assign sending_flag_o = res.sending;
  assign queued_count_o = res.queued;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##2 done_o)
    else $error("result missing two cycles after accept");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, 2))
    else $error("result without accepted word");

  a_refuse_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> !tx_load_o)
    else $error("refused write loaded the transmitter");

  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !tx_load_o) |-> (tx_byte_o == 8'h00))
    else $error("tx byte not zero without load");

endmodule
`default_nettype wire

>>> sim/utqb_tx_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utqb_tx_check
// Watches the command and result channels of the transmit queue, keeps its
// own copy of the ring, pointers and flags, predicts one result word per
// accepted command word and compares each result strobe against the oldest
// prediction.
// ----------------------------------------------------------------------------
module utqb_tx_check
  import utqb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic       busy_i,
  input  wire logic       operation_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       message_start_i,
  input  wire logic       done_i,
  input  wire logic       accepted_i,
  input  wire logic       tx_load_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       sending_flag_i,
  input  wire logic [6:0] queued_count_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  typedef struct packed {
    logic       accepted;
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       sending;
    logic [6:0] queued;
  } tx_word_t;

  logic [7:0]       ring_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] fill;
  logic             hold_free;
  logic             sending;
  tx_word_t         tx_expect_q [$];
  int unsigned      fails;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // advance the shadow queue by one command word and return its result
  task automatic queue_step(input op_e op, input logic [7:0] b, input logic msg_start,
                            output tx_word_t w);
    w          = '0;
    w.accepted = 1'b1;
    if (op == OP_WRITE) begin
      if (msg_start) begin
        sending   = 1'b1;
        hold_free = 1'b1;
      end
      if (fill >= CNT_FULL) begin
        w.accepted = 1'b0;
      end else if (hold_free) begin
        w.tx_load = 1'b1;
        w.tx_byte = b;
        hold_free = 1'b0;
      end else begin
        ring_mem[wr_ptr] = b;
        wr_ptr           = ptr_next(wr_ptr);
        fill             = fill + 1'b1;
      end
    end else begin
      hold_free = 1'b1;
      if (fill != '0) begin
        w.tx_load = 1'b1;
        w.tx_byte = ring_mem[rd_ptr];
        rd_ptr    = ptr_next(rd_ptr);
        fill      = fill - 1'b1;
        hold_free = 1'b0;
      end else begin
        sending = 1'b0;
      end
    end
    w.sending = sending;
    w.queued  = 7'(fill);
  endtask

  // four-state compare so an unknown result bit counts as a mismatch
  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tx_word_t want;
    tx_word_t pred;
    if (!rst_ni) begin
      rd_ptr       = '0;
      wr_ptr       = '0;
      fill         = '0;
      hold_free    = 1'b0;
      sending      = 1'b0;
      fails        = 0;
      tx_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // compare first: a word accepted at this edge cannot show its result yet
      if (done_i) begin
        if (tx_expect_q.size() == 0) begin
          $error("result word with no command word outstanding");
          fails++;
        end else begin
          want = tx_expect_q.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(accepted_i));
          check_field("tx_load", 8'(want.tx_load), 8'(tx_load_i));
          check_field("tx_byte", want.tx_byte, tx_byte_i);
          check_field("sending_flag", 8'(want.sending), 8'(sending_flag_i));
          check_field("queued_count", 8'(want.queued), 8'(queued_count_i));
        end
      end
      if (start_i && !busy_i) begin
        queue_step(op_e'(operation_i), data_byte_i, message_start_i, pred);
        tx_expect_q.push_back(pred);
      end
      fail_count_o <= fails;
      pending_o    <= tx_expect_q.size();
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Drives the transmit queue with a directed opening (writes before any
// message, bypass loads, idle events, ignored fields on events) and then
// random bursts shaped as messages, ring fills up to overflow, drains and
// noise, with random gaps between command words. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import utqb_pkg::*;

  localparam int unsigned RAND_WORDS  = 450;
  localparam int unsigned STALL_LIMIT = 200;
  localparam int unsigned DRAIN_WAIT  = 4;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        operation;
  logic [7:0]  data_byte;
  logic        message_start;
  logic        done;
  logic        accepted;
  logic        tx_load;
  logic [7:0]  tx_byte;
  logic        sending_flag;
  logic [6:0]  queued_count;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  int unsigned rand_words;
  bit          gaps_on;

  uart_tx_queue_with_bypass u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation),
    .data_byte_i     (data_byte),
    .message_start_i (message_start),
    .done_o          (done),
    .accepted_o      (accepted),
    .tx_load_o       (tx_load),
    .tx_byte_o       (tx_byte),
    .sending_flag_o  (sending_flag),
    .queued_count_o  (queued_count)
  );

  utqb_tx_check u_tx_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .operation_i     (operation),
    .data_byte_i     (data_byte),
    .message_start_i (message_start),
    .done_i          (done),
    .accepted_i      (accepted),
    .tx_load_i       (tx_load),
    .tx_byte_i       (tx_byte),
    .sending_flag_i  (sending_flag),
    .queued_count_i  (queued_count),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL uart_tx_queue_with_bypass");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one command word and hold it until the block takes it
  task automatic send_word(input op_e op, input logic [7:0] b, input logic msg_start);
    int unsigned gap;
    bit          was_busy;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    operation     <= op;
    data_byte     <= b;
    message_start <= msg_start;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
  endtask

  task automatic rand_word(input op_e op, input logic msg_start);
    send_word(op, 8'($urandom_range(0, 255)), msg_start);
    rand_words++;
  endtask

  // fill the ring past full, then empty it again
  task automatic fill_burst();
    int unsigned n;
    rand_word(OP_WRITE, 1'b1);
    n = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 8);
    repeat (n) rand_word(OP_WRITE, ($urandom_range(0, 7) == 0));
    // message start on a refused write still frees the holding register
    rand_word(OP_WRITE, 1'b1);
    n = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
    repeat (n) rand_word(OP_TXDONE, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned mode;
    int unsigned len;
    rst_n         = 1'b0;
    start         = 1'b0;
    operation     = OP_WRITE;
    data_byte     = '0;
    message_start = 1'b0;
    rand_words    = 0;
    gaps_on       = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // writes before any message start land in the ring
    send_word(OP_WRITE, 8'h00, 1'b0);
    send_word(OP_WRITE, 8'hFF, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);
    // event with an empty ring ends the message
    send_word(OP_TXDONE, 8'h00, 1'b0);
    // data and message start are ignored on events
    send_word(OP_TXDONE, 8'hFF, 1'b1);
    send_word(OP_WRITE, 8'hA5, 1'b1);
    send_word(OP_WRITE, 8'h5A, 1'b0);
    send_word(OP_WRITE, 8'h81, 1'b1);
    send_word(OP_WRITE, 8'h7E, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);
    // holding register left free by the idle event: bypass without a message
    send_word(OP_WRITE, 8'h3C, 1'b0);
    send_word(OP_WRITE, 8'hC3, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);
    send_word(OP_TXDONE, 8'h00, 1'b0);

    gaps_on = 1'b0;
    fill_burst();
    while (rand_words < RAND_WORDS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      mode    = $urandom_range(0, 9);
      case (mode)
        0, 1, 2, 3: begin
          // well-formed message: start, body with interleaved done events, drain
          len = $urandom_range(1, 20);
          rand_word(OP_WRITE, 1'b1);
          repeat (len) begin
            if ($urandom_range(0, 9) < 3) rand_word(OP_TXDONE, 1'b0);
            rand_word(OP_WRITE, 1'b0);
          end
          repeat (len + 2) rand_word(OP_TXDONE, 1'b0);
        end
        4: begin
          fill_burst();
        end
        5, 6, 7: begin
          len = $urandom_range(5, 30);
          repeat (len) rand_word(op_e'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
        end
        default: begin
          len = $urandom_range(3, 15);
          repeat (len) rand_word(OP_TXDONE, 1'($urandom_range(0, 1)));
        end
      endcase
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS uart_tx_queue_with_bypass");
    end else begin
      $display("FAIL uart_tx_queue_with_bypass");
    end
    $finish;
  end

endmodule
`default_nettype wire
